// File: rtl/sel_pkg.sv
`default_nettype none
package sel_pkg;
  localparam int DEPTH = 64;
  localparam int ELEM_BITS = 32;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SORT   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POP   = 7'b0000010,
    S_RUN   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_COPY  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

// File: rtl/sel_if.sv
`default_nettype none
interface sel_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] elem_value;
  modport source (output valid, cmd, elem_value, input ready);
  modport sink   (input valid, cmd, elem_value, output ready);
endinterface

interface sel_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] popped_value;
  logic [6:0]  entry_count;
  modport source (output valid, status, popped_value, entry_count, input ready);
  modport sink   (input valid, status, popped_value, entry_count, output ready);
endinterface
`default_nettype wire

// File: rtl/sel_ram.sv
`default_nettype none
module sel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/sortable_element_list.sv
// Append, unused codes, remove when empty: result registered as the request is taken;
// other removes read the store in S_POP first. Sort: per pass, one merge step per
//   element (S_RD reads both heads, S_CMP compares and writes scratch), then copy back.
// One request at a time; the next is taken once the result register is free.
// Reset (rst, synchronous) empties the list; the stores hold no reset value.
`default_nettype none
module sortable_element_list import sel_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  sel_cmd_if.sink  req,
  sel_rsp_if.source rsp
);
  state_t state;
  cnt_t   count;
  cnt_t   width, lo, mid, hi, a, b, k;
  logic   pick_a;
  elem_t  va;

  logic  el_we, sc_we;
  addr_t el_wa, el_ra, sc_wa, sc_ra;
  elem_t el_wd, el_rd, sc_wd, sc_rd;

  sel_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_elem (
    .clk, .we(el_we), .waddr(el_wa), .wdata(el_wd), .raddr(el_ra), .rdata(el_rd));
  sel_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_scr (
    .clk, .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));

  assign req.ready = (state == S_IDLE) && !rsp.valid;
  wire take = req.valid && req.ready;

  // element store has one read port: the a head and then the b head are read
  // in turn in S_RD.
  logic rd_phase;
  cnt_t copy_i;
  logic copy_ph;

  always_comb begin
    el_we = 1'b0; el_wa = count[ADDR_BITS-1:0];
    el_wd = req.elem_value[ELEM_BITS-1:0];
    el_ra = count[ADDR_BITS-1:0] - addr_t'(1);
    sc_we = 1'b0; sc_wa = k[ADDR_BITS-1:0]; sc_wd = pick_a ? va : el_rd;
    sc_ra = copy_i[ADDR_BITS-1:0];
    if (take && req.cmd == CMD_APPEND && count < cnt_t'(DEPTH)) el_we = 1'b1;
    if (state == S_RD) el_ra = rd_phase ? b[ADDR_BITS-1:0] : a[ADDR_BITS-1:0];
    if (state == S_CMP) sc_we = 1'b1;
    if (state == S_COPY && copy_ph) begin
      el_we = 1'b1; el_wa = copy_i[ADDR_BITS-1:0]; el_wd = sc_rd;
    end
  end

  wire a_ok = a < mid;
  wire b_ok = b < hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (take) begin
          rsp.popped_value <= '0;
          rsp.status <= ST_OK;
          priority case (req.cmd)
            CMD_APPEND: begin
              if (count < cnt_t'(DEPTH)) begin
                count <= count + cnt_t'(1);
                rsp.entry_count <= 7'(count + cnt_t'(1));
              end else begin
                rsp.status <= ST_FULL; rsp.entry_count <= 7'(count);
              end
              rsp.valid <= 1'b1;
            end
            CMD_REMOVE: begin
              if (count == '0) begin
                rsp.status <= ST_EMPTY; rsp.entry_count <= '0; rsp.valid <= 1'b1;
              end else state <= S_POP;
            end
            CMD_SORT: begin
              rsp.entry_count <= 7'(count);
              width <= cnt_t'(1); lo <= '0;
              state <= S_RUN;
            end
            default: begin
              rsp.entry_count <= 7'(count); rsp.valid <= 1'b1;
            end
          endcase
        end
        S_POP: begin
          rsp.popped_value <= 32'(el_rd);
          count <= count - cnt_t'(1);
          rsp.entry_count <= 7'(count - cnt_t'(1));
          rsp.valid <= 1'b1; state <= S_IDLE;
        end
        S_RUN: begin
          // start a run pair at lo, finish the pass, or end the sort
          if (width >= count) state <= S_DONE;
          else if (lo >= count) begin
            copy_i <= '0; copy_ph <= 1'b0; state <= S_COPY;
          end else begin
            a <= lo; k <= lo;
            mid <= (lo + width > count) ? count : lo + width;
            b <= (lo + width > count) ? count : lo + width;
            hi <= ({1'b0, lo} + {width, 1'b0} > {1'b0, count}) ? count
                  : CNT_BITS'({1'b0, lo} + {width, 1'b0});
            rd_phase <= 1'b0; state <= S_RD;
          end
        end
        S_RD: begin
          if (!a_ok && !b_ok) begin
            lo <= hi; state <= S_RUN;
          end else if (!rd_phase) begin
            rd_phase <= 1'b1;
          end else begin
            va <= el_rd;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // el_rd holds b head; va holds a head
          k <= k + cnt_t'(1);
          if (pick_a) a <= a + cnt_t'(1); else b <= b + cnt_t'(1);
          rd_phase <= 1'b0; state <= S_RD;
        end
        S_COPY: begin
          if (copy_ph) begin
            copy_ph <= 1'b0;
            if (copy_i + cnt_t'(1) >= count) begin
              width <= CNT_BITS'({width, 1'b0}); lo <= '0; state <= S_RUN;
            end
            copy_i <= copy_i + cnt_t'(1);
          end else copy_ph <= 1'b1;
        end
        S_DONE: begin
          rsp.valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // merge choice, combinational from registered heads
  always_comb pick_a = a_ok && (!b_ok || va < el_rd);
endmodule
`default_nettype wire

// File: rtl/sel_checker.sv
`default_nettype none
module sel_checker import sel_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic [1:0] status,
  input wire logic [31:0] popped_value,
  input wire logic [6:0] entry_count
);
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_count <= 7'(DEPTH)) else $error("count beyond depth");
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == 7'(DEPTH))
    else $error("full not at depth");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> entry_count == 7'd0 && popped_value == 32'd0)
    else $error("bad empty result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count))
    else $error("stalled result changed");
  a_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready) else $error("request taken while result waits");
endmodule

bind sortable_element_list sel_checker u_chk (
  .clk, .rst, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.status),
  .popped_value(rsp.popped_value), .entry_count(rsp.entry_count));
`default_nettype wire

// File: test/sortable_element_list_test.sv
`timescale 1ns / 100ps
`default_nettype none
module sortable_element_list_test;
  import sel_pkg::*;

  class list_scoreboard;
    elem_t held[$];
    logic [1:0] exp_status[$];
    elem_t exp_popped[$];
    logic [6:0] exp_count[$];
    int errors;

    function void note_request(logic [1:0] cmd, elem_t value);
      logic [1:0] st;
      elem_t pv;
      st = ST_OK;
      pv = '0;
      if (cmd == CMD_APPEND) begin
        if (held.size() >= DEPTH) st = ST_FULL;
        else held.push_back(value);
      end else if (cmd == CMD_REMOVE) begin
        if (held.size() == 0) st = ST_EMPTY;
        else pv = held.pop_back();
      end else if (cmd == CMD_SORT) begin
        held.sort();
      end
      exp_status.push_back(st);
      exp_popped.push_back(pv);
      exp_count.push_back(7'(held.size()));
    endfunction

    function void check_result(logic [1:0] st, elem_t pv, logic [6:0] cnt);
      logic [1:0] es;
      elem_t ep;
      logic [6:0] ec;
      if (exp_status.size() == 0) begin
        $error("unexpected result status=%0d", st);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ep = exp_popped.pop_front();
      ec = exp_count.pop_front();
      if (st !== es) begin
        $error("status expected %0d actual %0d", es, st);
        errors++;
      end
      if (pv !== ep) begin
        $error("popped_value expected %h actual %h", ep, pv);
        errors++;
      end
      if (cnt !== ec) begin
        $error("entry_count expected %0d actual %0d", ec, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  sel_cmd_if req();
  sel_rsp_if rsp();
  list_scoreboard sb = new();
  int cycles = 0;
  bit sending_done = 0;
  bit no_gaps = 0;

  sortable_element_list u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // response side: random stalls, checks at each accept
  initial begin
    int stall;
    rsp.ready = 0;
    @(posedge clk iff !rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        rsp.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk iff rsp.valid);
      sb.check_result(rsp.status, rsp.popped_value, rsp.entry_count);
    end
  end

  task automatic send_request(logic [1:0] cmd, elem_t value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.cmd <= cmd;
    req.elem_value <= value;
    @(posedge clk iff req.ready);
    sb.note_request(cmd, value);
  endtask

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return elem_t'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int wait_cycles;
    req.valid = 0;
    req.cmd = CMD_APPEND;
    req.elem_value = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty cases, extremes, unused code, sorts
    send_request(CMD_REMOVE, '0);
    send_request(CMD_SORT, '0);
    send_request(2'd3, '1);
    send_request(CMD_APPEND, 32'hFFFF_FFFF);
    send_request(CMD_SORT, '0);
    send_request(CMD_APPEND, 32'h0000_0000);
    send_request(CMD_APPEND, 32'h8000_0000);
    send_request(CMD_APPEND, 32'h7FFF_FFFF);
    send_request(CMD_APPEND, 32'h0000_0001);
    send_request(CMD_APPEND, 32'h7FFF_FFFF);
    send_request(CMD_SORT, '0);
    repeat (6) send_request(CMD_REMOVE, '0);
    send_request(CMD_REMOVE, '0);
    // fill past full, sort full list
    no_gaps = 1;
    repeat (DEPTH + 2) send_request(CMD_APPEND, $urandom);
    send_request(CMD_SORT, '0);
    no_gaps = 0;
    repeat (DEPTH + 1) send_request(CMD_REMOVE, '0);
    // random: bursts of appends, sorts, removes and unused codes
    for (int i = 0; i < 500; i++) begin
      int r;
      no_gaps = (i / 60) % 3 == 1;
      r = $urandom_range(0, 99);
      if (r < 50) send_request(CMD_APPEND, rand_elem());
      else if (r < 80) send_request(CMD_REMOVE, '0);
      else if (r < 95) send_request(CMD_SORT, '0);
      else send_request(2'd3, $urandom);
    end
    req.valid <= 0;
    no_gaps = 0;
    wait_cycles = 0;
    while (sb.exp_status.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.exp_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
